FILE: design/cicd_pkg.sv
// ----------------------------------------------------------------------------
// cicd_pkg
// Shared types and constants of the cloud-in-cell charge deposit grid.
// ----------------------------------------------------------------------------
package cicd_pkg;

  // default grid size
  localparam int GRID_X_DEF = 64;
  localparam int GRID_Y_DEF = 64;

  // field widths
  localparam int CELL_W    = 40;
  localparam int POS_W     = 32;
  localparam int SCALE_W   = 24;
  localparam int WEIGHT_W  = 16;
  localparam int IDX_W     = 6;
  localparam int FRAC_W    = 16;
  localparam int CMD_W     = 2;
  localparam int CFG_IDX_W = 4;

  // derived datapath widths
  localparam int MUL_W    = POS_W + SCALE_W;        // position times scale
  localparam int SCALED_W = MUL_W - FRAC_W;         // position in cell units, Q.16
  localparam int BASE_W   = SCALED_W - FRAC_W + 2;  // base index plus carry and +1
  localparam int WF_W     = FRAC_W + 1;             // fraction or one minus it
  localparam int PROD_W   = 2 * WF_W;               // product of two weights
  localparam int SHARE_W  = PROD_W;                 // share after weight and shift
  localparam int SHMUL_W  = PROD_W + WEIGHT_W;

  localparam int CORNERS = 4;
  localparam int CNR_W   = $clog2(CORNERS + 1);

  localparam logic [WF_W-1:0]    ONE_Q16     = WF_W'(1) << FRAC_W;
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(1) << FRAC_W;

  // commands
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEPOSIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_X = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y = 4'd1;

  typedef enum logic [3:0] {
    ST_BOOT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCALE,
    ST_FRAC,
    ST_SHARE,
    ST_RMW,
    ST_READ,
    ST_FINISH
  } cicd_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scale;
    logic frac;
    logic share;
    logic sweep;
    logic rmw;
    logic read;
    logic finish;
  } cicd_ctl_t;

  // datapath to controller
  typedef struct packed {
    logic sweep_last;
    logic rmw_last;
    logic out_free;
  } cicd_sts_t;

endpackage

FILE: design/cic_charge_deposit_grid_top.sv
// ----------------------------------------------------------------------------
// cic_charge_deposit_grid_top
// Cloud-in-cell deposit of particle weight onto a 2D grid, with clear and read.
// ----------------------------------------------------------------------------
// One item at a time. A deposit passes through the scale, frac, share, rmw
// and finish steps: the scale step scales both coordinates, the frac step
// splits base cell and fraction and forms the bilinear weight products, the
// share step multiplies by the particle weight, the rmw step runs the four
// read-modify-write updates through the single grid memory (read and write
// ports overlap by one corner), and the finish step loads the result
// register. A read passes through the read step to the finish step, an
// unused command goes straight to the finish step. A clear walks the grid
// memory one cell a cycle, then loads its result. A previous result still
// waiting in the output register holds the sequencer in its last step until
// it is taken. After reset the same walk runs with in_ready low.
// A finished result waits in the output register while the next item is taken.
module cic_charge_deposit_grid_top #(
  parameter int GRID_X = cicd_pkg::GRID_X_DEF,
  parameter int GRID_Y = cicd_pkg::GRID_Y_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [cicd_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [cicd_pkg::SCALE_W-1:0]  cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [cicd_pkg::CMD_W-1:0]    cmd,
  input  logic [cicd_pkg::POS_W-1:0]    pos_x,
  input  logic [cicd_pkg::POS_W-1:0]    pos_y,
  input  logic [cicd_pkg::WEIGHT_W-1:0] weight,
  input  logic [cicd_pkg::IDX_W-1:0]    cell_row,
  input  logic [cicd_pkg::IDX_W-1:0]    cell_col,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cicd_pkg::CELL_W-1:0]   cell_value,
  output logic                          dropped,
  output logic                          saturated
);
  import cicd_pkg::*;

  cicd_ctl_t ctl;
  cicd_sts_t sts;

  cicd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts),
    .ctl      (ctl)
  );

  cicd_datapath #(
    .GRID_X (GRID_X),
    .GRID_Y (GRID_Y)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .pos_x      (pos_x),
    .pos_y      (pos_y),
    .weight     (weight),
    .cell_row   (cell_row),
    .cell_col   (cell_col),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .cell_value (cell_value),
    .dropped    (dropped),
    .saturated  (saturated)
  );

endmodule

FILE: design/cicd_ctrl.sv
// ----------------------------------------------------------------------------
// cicd_ctrl
// Sequencer of the deposit grid: boot clear, command decode and step control.
// ----------------------------------------------------------------------------
module cicd_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cicd_pkg::CMD_W-1:0] cmd,
  input  cicd_pkg::cicd_sts_t       sts,
  output cicd_pkg::cicd_ctl_t       ctl
);
  import cicd_pkg::*;

  cicd_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_BOOT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_BOOT: begin
        if (sts.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          priority if (cmd == CMD_CLEAR) state_next = ST_CLEAR;
          else if (cmd == CMD_DEPOSIT)   state_next = ST_SCALE;
          else if (cmd == CMD_READ)      state_next = ST_READ;
          else                           state_next = ST_FINISH;
        end
      end
      ST_CLEAR: begin
        if (sts.sweep_last) state_next = ST_FINISH;
      end
      ST_SCALE:  state_next = ST_FRAC;
      ST_FRAC:   state_next = ST_SHARE;
      ST_SHARE:  state_next = ST_RMW;
      ST_RMW: begin
        if (sts.rmw_last) state_next = ST_FINISH;
      end
      ST_READ:   state_next = ST_FINISH;
      ST_FINISH: begin
        if (sts.out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_BOOT;
    endcase
  end

  always_comb begin
    ctl      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_BOOT:   ctl.sweep = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        ctl.load = in_valid;
      end
      ST_CLEAR:  ctl.sweep  = 1'b1;
      ST_SCALE:  ctl.scale  = 1'b1;
      ST_FRAC:   ctl.frac   = 1'b1;
      ST_SHARE:  ctl.share  = 1'b1;
      ST_RMW:    ctl.rmw    = 1'b1;
      ST_READ:   ctl.read   = 1'b1;
      ST_FINISH: ctl.finish = sts.out_free;
      default:   ctl        = '0;
    endcase
  end

endmodule

FILE: design/cicd_datapath.sv
// ----------------------------------------------------------------------------
// cicd_datapath
// Scale and split, bilinear shares, grid memory read-modify-write, readout.
// ----------------------------------------------------------------------------
module cicd_datapath #(
  parameter int GRID_X = cicd_pkg::GRID_X_DEF,
  parameter int GRID_Y = cicd_pkg::GRID_Y_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cicd_pkg::cicd_ctl_t           ctl,
  output cicd_pkg::cicd_sts_t           sts,
  input  logic                          cfg_we,
  input  logic [cicd_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic [cicd_pkg::SCALE_W-1:0]  cfg_wdata,
  input  logic [cicd_pkg::CMD_W-1:0]    cmd,
  input  logic [cicd_pkg::POS_W-1:0]    pos_x,
  input  logic [cicd_pkg::POS_W-1:0]    pos_y,
  input  logic [cicd_pkg::WEIGHT_W-1:0] weight,
  input  logic [cicd_pkg::IDX_W-1:0]    cell_row,
  input  logic [cicd_pkg::IDX_W-1:0]    cell_col,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [cicd_pkg::CELL_W-1:0]   cell_value,
  output logic                          dropped,
  output logic                          saturated
);
  import cicd_pkg::*;

  localparam int N  = GRID_X * GRID_Y;
  localparam int AW = $clog2(N);
  localparam int XW = $clog2(GRID_X);
  localparam int YW = $clog2(GRID_Y);

  // configuration
  logic [SCALE_W-1:0] scale_x, scale_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x <= SCALE_RESET;
      scale_y <= SCALE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_SCALE_X: scale_x <= cfg_wdata;
        REG_SCALE_Y: scale_y <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // captured item
  logic [CMD_W-1:0]    cmd_q;
  logic [POS_W-1:0]    pos_x_q, pos_y_q;
  logic [WEIGHT_W-1:0] weight_q;
  logic [IDX_W-1:0]    row_q, col_q;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q    <= cmd;
      pos_x_q  <= pos_x;
      pos_y_q  <= pos_y;
      weight_q <= weight;
      row_q    <= cell_row;
      col_q    <= cell_col;
    end
  end

  // scale to cell units
  logic [MUL_W-1:0]    mul_x, mul_y;
  logic [SCALED_W-1:0] sx, sy;

  assign mul_x = MUL_W'(pos_x_q) * MUL_W'(scale_x);
  assign mul_y = MUL_W'(pos_y_q) * MUL_W'(scale_y);

  always_ff @(posedge clk) begin
    if (ctl.scale) begin
      sx <= mul_x[MUL_W-1:FRAC_W];
      sy <= mul_y[MUL_W-1:FRAC_W];
    end
  end

  // add one half: the fraction flips its top bit, the carry goes to the base
  logic [WF_W-1:0]   fx, fy, gx, gy;
  logic [BASE_W-1:0] bx_next, by_next, bx, by;
  logic [PROD_W-1:0] p_next [CORNERS];
  logic [PROD_W-1:0] p [CORNERS];

  assign fx = {1'b0, ~sx[FRAC_W-1], sx[FRAC_W-2:0]};
  assign fy = {1'b0, ~sy[FRAC_W-1], sy[FRAC_W-2:0]};
  assign gx = ONE_Q16 - fx;
  assign gy = ONE_Q16 - fy;
  assign bx_next = BASE_W'(sx[SCALED_W-1:FRAC_W]) + BASE_W'(sx[FRAC_W-1]);
  assign by_next = BASE_W'(sy[SCALED_W-1:FRAC_W]) + BASE_W'(sy[FRAC_W-1]);

  // corner order: (x,y), (x,y+1), (x+1,y), (x+1,y+1)
  assign p_next[0] = PROD_W'(gx) * PROD_W'(gy);
  assign p_next[1] = PROD_W'(gx) * PROD_W'(fy);
  assign p_next[2] = PROD_W'(fx) * PROD_W'(gy);
  assign p_next[3] = PROD_W'(fx) * PROD_W'(fy);

  always_ff @(posedge clk) begin
    if (ctl.frac) begin
      bx <= bx_next;
      by <= by_next;
      for (int i = 0; i < CORNERS; i++) p[i] <= p_next[i];
    end
  end

  // shares, grid check and addresses; shifted out one corner a step
  logic [SHMUL_W-1:0] shm [CORNERS];
  logic [BASE_W-1:0]  cx [CORNERS];
  logic [BASE_W-1:0]  cy [CORNERS];
  logic               ok_next [CORNERS];
  logic [AW-1:0]      addr_next [CORNERS];
  logic [SHARE_W-1:0] share [CORNERS];
  logic               ok [CORNERS];
  logic [AW-1:0]      caddr [CORNERS];
  logic               drop_q;
  logic               drop_next;

  always_comb begin
    drop_next = 1'b0;
    for (int i = 0; i < CORNERS; i++) begin
      shm[i]       = SHMUL_W'(p[i]) * SHMUL_W'(weight_q);
      cx[i]        = (i >= 2) ? bx + BASE_W'(1) : bx;
      cy[i]        = (i % 2 == 1) ? by + BASE_W'(1) : by;
      ok_next[i]   = (32'(cx[i]) < GRID_X) && (32'(cy[i]) < GRID_Y);
      addr_next[i] = AW'(cx[i][XW-1:0]) * AW'(GRID_Y) + AW'(cy[i][YW-1:0]);
      drop_next    = drop_next | ~ok_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.share) begin
      drop_q <= drop_next;
      for (int i = 0; i < CORNERS; i++) begin
        share[i] <= shm[i][SHMUL_W-1:FRAC_W];
        ok[i]    <= ok_next[i];
        caddr[i] <= addr_next[i];
      end
    end else if (ctl.rmw) begin
      for (int i = 0; i < CORNERS - 1; i++) begin
        share[i] <= share[i+1];
        ok[i]    <= ok[i+1];
        caddr[i] <= caddr[i+1];
      end
    end
  end

  // corner step counter: read corner k, write corner k-1
  logic [CNR_W-1:0] k;

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (ctl.rmw) begin
      k <= (k == CNR_W'(CORNERS)) ? '0 : k + CNR_W'(1);
    end
  end

  logic               pend_ok;
  logic [AW-1:0]      pend_addr;
  logic [SHARE_W-1:0] pend_share;
  logic               sat_q;

  always_ff @(posedge clk) begin
    if (ctl.rmw) begin
      pend_ok    <= ok[0];
      pend_addr  <= caddr[0];
      pend_share <= share[0];
    end
  end

  logic                rmw_rd, rmw_wr;
  logic [CELL_W:0]     sum;
  logic [CELL_W-1:0]   sum_sat;
  logic [CELL_W-1:0]   rd_data;

  assign rmw_rd  = ctl.rmw && (k != CNR_W'(CORNERS)) && ok[0];
  assign rmw_wr  = ctl.rmw && (k != '0) && pend_ok;
  assign sum     = (CELL_W + 1)'(rd_data) + (CELL_W + 1)'(pend_share);
  assign sum_sat = sum[CELL_W] ? '1 : sum[CELL_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      sat_q <= 1'b0;
    end else if (rmw_wr && sum[CELL_W]) begin
      sat_q <= 1'b1;
    end
  end

  // clearing sweep
  logic [AW-1:0] sweep_cnt;
  logic          sweep_last;

  assign sweep_last = (sweep_cnt == AW'(N - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
    end else if (ctl.sweep) begin
      sweep_cnt <= sweep_last ? '0 : sweep_cnt + AW'(1);
    end
  end

  // readout
  logic          read_ok, read_ok_q;
  logic [AW-1:0] read_addr;

  assign read_ok   = (32'(row_q) < GRID_X) && (32'(col_q) < GRID_Y);
  assign read_addr = AW'(32'(row_q) * 32'(GRID_Y) + 32'(col_q));

  always_ff @(posedge clk) begin
    if (ctl.read) read_ok_q <= read_ok;
  end

  // grid memory: one write and one read port
  logic [CELL_W-1:0] grid [N];
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [CELL_W-1:0] wr_data;

  always_comb begin
    if (ctl.sweep) begin
      wr_en   = 1'b1;
      wr_addr = sweep_cnt;
      wr_data = '0;
    end else begin
      wr_en   = rmw_wr;
      wr_addr = pend_addr;
      wr_data = sum_sat;
    end
    if (ctl.read) begin
      rd_en   = read_ok;
      rd_addr = read_addr;
    end else begin
      rd_en   = rmw_rd;
      rd_addr = caddr[0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) grid[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= grid[rd_addr];
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      cell_value <= (cmd_q == CMD_READ && read_ok_q) ? rd_data : '0;
      dropped    <= (cmd_q == CMD_DEPOSIT) && drop_q;
      saturated  <= (cmd_q == CMD_DEPOSIT) && sat_q;
    end
  end

  assign sts.sweep_last = sweep_last;
  assign sts.rmw_last   = (k == CNR_W'(CORNERS));
  assign sts.out_free   = !out_valid || out_ready;

endmodule

FILE: design/cicd_checker.sv
// ----------------------------------------------------------------------------
// cicd_checker
// Port-level checks of the deposit grid, bound to the top level.
// ----------------------------------------------------------------------------
module cicd_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [cicd_pkg::CELL_W-1:0] cell_value,
  input logic                        dropped,
  input logic                        saturated
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cell_value)
      && $stable(dropped) && $stable(saturated))
    else $error("stalled result changed");

  // only reads return a value, and reads never raise the deposit flags
  a_value_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid && (cell_value != '0) |-> !dropped && !saturated)
    else $error("read result carries deposit flags");

  // the clearing walk after reset holds off input
  a_boot_busy: assert property (@(posedge clk)
    $past(rst) && !rst |-> !in_ready && !out_valid)
    else $error("input taken during boot clear");

  // one item at a time: busy right after a transfer
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second transfer while busy");

endmodule

bind cic_charge_deposit_grid_top cicd_checker u_cicd_checker (.*);

FILE: verif/tb_cic_charge_deposit_grid_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cic_charge_deposit_grid_top
// Self-checking bench for the cloud-in-cell deposit grid: a directed table of
// clears, deposits at the grid edges and reads, then phases of random traffic
// under several scale settings, including a hot cell driven into saturation.
// A shadow grid predicts the results the table does not fix; both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_cic_charge_deposit_grid_top;
  import cicd_pkg::*;

  localparam int GRID_X = GRID_X_DEF;
  localparam int GRID_Y = GRID_Y_DEF;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = 40;
  localparam int AIM_SPAN = GRID_X + 2;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 4'd2;
  localparam logic [63:0] CELL_MAX = (64'd1 << CELL_W) - 64'd1;
  localparam logic [63:0] HALF_CELL = 64'd1 << (FRAC_W - 1);

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [POS_W-1:0]    pos_x;
    logic [POS_W-1:0]    pos_y;
    logic [WEIGHT_W-1:0] weight;
    logic [IDX_W-1:0]    cell_row;
    logic [IDX_W-1:0]    cell_col;
  } grid_cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0] value;
    logic              dropped;
    logic              saturated;
  } cell_result_t;

  typedef struct packed {
    grid_cmd_t    op;
    logic         typed;
    cell_result_t want;
  } directed_row_t;

  // Rows with typed = 0 take their expectation from the shadow grid.
  localparam directed_row_t DIRECTED_ROWS [24] = '{
    '{'{CMD_READ, 32'h0, 32'h0, 16'h0, 6'd0, 6'd0}, 1'b1, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_READ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 6'd63, 6'd63},
      1'b1, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_UNUSED, 32'h1234_5678, 32'h9ABC_DEF0, 16'hFFFF, 6'd5, 6'd9},
      1'b1, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_DEPOSIT, 32'h0, 32'h0, 16'hFFFF, 6'd0, 6'd0}, 1'b1, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_READ, 32'h0, 32'h0, 16'h0, 6'd0, 6'd0}, 1'b1, '{40'h3FFF_C000, 1'b0, 1'b0}},
    '{'{CMD_READ, 32'h0, 32'h0, 16'h0, 6'd1, 6'd1}, 1'b1, '{40'h3FFF_C000, 1'b0, 1'b0}},
    '{'{CMD_READ, 32'h0, 32'h0, 16'h0, 6'd0, 6'd1}, 1'b1, '{40'h3FFF_C000, 1'b0, 1'b0}},
    '{'{CMD_DEPOSIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 6'd0, 6'd0},
      1'b1, '{40'h0, 1'b1, 1'b0}},
    '{'{CMD_DEPOSIT, 32'h003F_0000, 32'h000A_4000, 16'h04D2, 6'd0, 6'd0},
      1'b0, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_READ, 32'h0, 32'h0, 16'h0, 6'd63, 6'd10}, 1'b0, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_DEPOSIT, 32'h0005_0000, 32'h003F_8000, 16'h8000, 6'd0, 6'd0},
      1'b1, '{40'h0, 1'b1, 1'b0}},
    '{'{CMD_DEPOSIT, 32'h0014_4CCC, 32'h0028_B333, 16'h0, 6'd0, 6'd0},
      1'b1, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_DEPOSIT, 32'h001F_8000, 32'h0011_8000, 16'hFFFF, 6'd0, 6'd0},
      1'b1, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_READ, 32'h0, 32'h0, 16'h0, 6'd32, 6'd18}, 1'b1, '{40'hFF_FF00_00, 1'b0, 1'b0}},
    '{'{CMD_READ, 32'h0, 32'h0, 16'h0, 6'd33, 6'd19}, 1'b1, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_DEPOSIT, 32'h000C_570A, 32'h0007_E666, 16'h9ABC, 6'd0, 6'd0},
      1'b0, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_READ, 32'h0, 32'h0, 16'h0, 6'd12, 6'd8}, 1'b0, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_READ, 32'h0, 32'h0, 16'h0, 6'd13, 6'd9}, 1'b0, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_CLEAR, 32'hDEAD_BEEF, 32'h0F0F_0F0F, 16'hA5A5, 6'd21, 6'd42},
      1'b1, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_READ, 32'h0, 32'h0, 16'h0, 6'd32, 6'd18}, 1'b1, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_DEPOSIT, 32'h0, 32'hFFFF_FFFF, 16'hFFFF, 6'd0, 6'd0},
      1'b1, '{40'h0, 1'b1, 1'b0}},
    '{'{CMD_DEPOSIT, 32'h0000_4000, 32'h0, 16'hFFFF, 6'd0, 6'd0},
      1'b0, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_READ, 32'h0, 32'h0, 16'h0, 6'd0, 6'd0}, 1'b0, '{40'h0, 1'b0, 1'b0}},
    '{'{CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 6'd63, 6'd63},
      1'b1, '{40'h0, 1'b0, 1'b0}}
  };

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = '0;
  logic [SCALE_W-1:0]   cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CMD_W-1:0]     cmd = CMD_CLEAR;
  logic [POS_W-1:0]     pos_x = '0;
  logic [POS_W-1:0]     pos_y = '0;
  logic [WEIGHT_W-1:0]  weight = '0;
  logic [IDX_W-1:0]     cell_row = '0;
  logic [IDX_W-1:0]     cell_col = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CELL_W-1:0]    cell_value;
  logic                 dropped;
  logic                 saturated;

  // shadow of the grid and the scale registers
  logic [CELL_W-1:0]  grid_cells [GRID_X*GRID_Y];
  logic [SCALE_W-1:0] scale_x_q = SCALE_RESET;
  logic [SCALE_W-1:0] scale_y_q = SCALE_RESET;
  bit                 share_clipped;
  logic [IDX_W-1:0]   last_x = '0;
  logic [IDX_W-1:0]   last_y = '0;
  logic [IDX_W-1:0]   hot_x;
  logic [IDX_W-1:0]   hot_y;

  cell_result_t cell_results_due [$];
  cell_result_t want_now;

  bit calm_tail = 1'b0;
  int stall_left = 0;
  int cycle_count = 0;
  int fail_count = 0;
  int n_deposits = 0;
  int n_reads = 0;
  int n_clears = 0;
  int n_results = 0;
  int n_drop_seen = 0;
  int n_sat_seen = 0;

  cic_charge_deposit_grid_top #(
    .GRID_X(GRID_X),
    .GRID_Y(GRID_Y)
  ) uut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .weight(weight),
    .cell_row(cell_row),
    .cell_col(cell_col),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cell_value(cell_value),
    .dropped(dropped),
    .saturated(saturated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    foreach (grid_cells[i]) grid_cells[i] = '0;
  end

  // Add one corner share; report whether the corner fell outside the grid.
  function automatic bit add_share(logic [63:0] cx, logic [63:0] cy, logic [63:0] share);
    logic [63:0] sum;
    int          idx;
    if (cx >= GRID_X || cy >= GRID_Y) return 1'b1;
    idx = int'(cx) * GRID_Y + int'(cy);
    sum = 64'(grid_cells[idx]) + share;
    if (sum > CELL_MAX) begin
      sum = CELL_MAX;
      share_clipped = 1'b1;
    end
    grid_cells[idx] = sum[CELL_W-1:0];
    return 1'b0;
  endfunction

  function automatic cell_result_t predict_grid_op(grid_cmd_t op);
    cell_result_t res;
    logic [63:0]  tx, ty, bx, by, fx, fy, gx, gy, w;
    bit           drop;
    res = '0;
    drop = 1'b0;
    share_clipped = 1'b0;
    case (op.cmd)
      CMD_CLEAR: begin
        foreach (grid_cells[i]) grid_cells[i] = '0;
      end
      CMD_DEPOSIT: begin
        tx = ((64'(op.pos_x) * 64'(scale_x_q)) >> FRAC_W) + HALF_CELL;
        ty = ((64'(op.pos_y) * 64'(scale_y_q)) >> FRAC_W) + HALF_CELL;
        w  = 64'(op.weight);
        bx = tx >> FRAC_W;
        by = ty >> FRAC_W;
        fx = tx & 64'hFFFF;
        fy = ty & 64'hFFFF;
        gx = 64'(ONE_Q16) - fx;
        gy = 64'(ONE_Q16) - fy;
        drop |= add_share(bx, by, (gx * gy * w) >> FRAC_W);
        drop |= add_share(bx, by + 1, (gx * fy * w) >> FRAC_W);
        drop |= add_share(bx + 1, by, (fx * gy * w) >> FRAC_W);
        drop |= add_share(bx + 1, by + 1, (fx * fy * w) >> FRAC_W);
        res.dropped = drop;
        res.saturated = share_clipped;
        last_x = bx[IDX_W-1:0];
        last_y = by[IDX_W-1:0];
      end
      CMD_READ: begin
        if (op.cell_row < GRID_X && op.cell_col < GRID_Y)
          res.value = grid_cells[int'(op.cell_row) * GRID_Y + int'(op.cell_col)];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Pick a position that lands near the grid under the given scale.
  function automatic logic [POS_W-1:0] aim_position(logic [SCALE_W-1:0] scale);
    logic [63:0] cells;
    logic [63:0] pos;
    if (scale == 0 || $urandom_range(0, 9) == 0) return $urandom();
    cells = 64'($urandom_range(0, AIM_SPAN << FRAC_W));
    pos = (cells << FRAC_W) / scale;
    return (pos > 64'hFFFF_FFFF) ? POS_W'($urandom()) : pos[POS_W-1:0];
  endfunction

  function automatic grid_cmd_t random_op();
    grid_cmd_t   op;
    int unsigned pick;
    op.cmd = CMD_DEPOSIT;
    op.pos_x = $urandom();
    op.pos_y = $urandom();
    op.weight = WEIGHT_W'($urandom());
    op.cell_row = IDX_W'($urandom());
    op.cell_col = IDX_W'($urandom());
    pick = $urandom_range(0, 999);
    if (pick < 8) begin
      op.cmd = CMD_CLEAR;
    end else if (pick < 40) begin
      op.cmd = CMD_UNUSED;
    end else if (pick < 380) begin
      op.cmd = CMD_READ;
      // mostly look where the last particle went
      if ($urandom_range(0, 9) < 7) begin
        op.cell_row = last_x + IDX_W'($urandom_range(0, 1));
        op.cell_col = last_y + IDX_W'($urandom_range(0, 1));
      end
    end else begin
      op.pos_x = aim_position(scale_x_q);
      op.pos_y = aim_position(scale_y_q);
      case ($urandom_range(0, 7))
        0: op.weight = '0;
        1: op.weight = '1;
        default: ;
      endcase
    end
    return op;
  endfunction

  // Pile full-weight particles on one cell center until it clips.
  function automatic grid_cmd_t hot_op();
    grid_cmd_t   op;
    int unsigned pick;
    op = random_op();
    pick = $urandom_range(0, 99);
    if (pick < 90) begin
      op.cmd = CMD_DEPOSIT;
      op.pos_x = {10'd0, hot_x, 16'h8000};
      op.pos_y = {10'd0, hot_y, 16'h8000};
      op.weight = '1;
    end else if (pick < 97) begin
      op.cmd = CMD_READ;
      op.cell_row = hot_x + 1'b1;
      op.cell_col = hot_y + 1'b1;
    end else if (op.cmd == CMD_CLEAR) begin
      op.cmd = CMD_UNUSED;
    end
    return op;
  endfunction

  task automatic send_op(input grid_cmd_t op, input bit typed, input cell_result_t want);
    cell_result_t res;
    in_valid <= 1'b1;
    cmd <= op.cmd;
    pos_x <= op.pos_x;
    pos_y <= op.pos_y;
    weight <= op.weight;
    cell_row <= op.cell_row;
    cell_col <= op.cell_col;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    res = predict_grid_op(op);
    cell_results_due.push_back(typed ? want : res);
    case (op.cmd)
      CMD_CLEAR: n_clears++;
      CMD_DEPOSIT: n_deposits++;
      CMD_READ: n_reads++;
      default: ;
    endcase
    if (!calm_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // Hold off the sender until every outstanding result is back.
  task automatic settle();
    in_valid <= 1'b0;
    while (cell_results_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [SCALE_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_addr <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    if (addr == REG_SCALE_X) scale_x_q = data;
    else if (addr == REG_SCALE_Y) scale_y_q = data;
  endtask

  task automatic run_phase(input int phase);
    logic [SCALE_W-1:0] sx, sy;
    int                 count;
    bit                 poke_unused;
    bit                 hot;
    grid_cmd_t          op;
    poke_unused = 1'b0;
    hot = 1'b0;
    sx = SCALE_RESET;
    sy = SCALE_RESET;
    count = 200;
    case (phase)
      0: count = 400;
      1: begin
        sx = '0;
        sy = '1;
        count = 120;
      end
      2: begin
        sx = '1;
        sy = '0;
        count = 120;
      end
      3: begin
        sx = SCALE_W'($urandom_range(24'h00_2000, 24'h06_0000));
        sy = SCALE_W'($urandom_range(24'h00_2000, 24'h06_0000));
        poke_unused = 1'b1;
        count = 300;
      end
      4: begin
        hot = 1'b1;
        count = 340;
      end
      5: begin
        sx = SCALE_W'($urandom_range(24'h00_4000, 24'h04_0000));
        sy = SCALE_W'($urandom_range(24'h00_4000, 24'h04_0000));
        poke_unused = 1'b1;
        count = 250;
      end
      default: calm_tail = 1'b1;
    endcase
    write_reg(REG_SCALE_X, sx);
    write_reg(REG_SCALE_Y, sy);
    if (poke_unused)
      write_reg(CFG_IDX_W'($urandom_range(REG_FIRST_UNUSED, 2**CFG_IDX_W - 1)),
                SCALE_W'($urandom()));
    cfg_we <= 1'b0;
    if (hot) begin
      hot_x = IDX_W'($urandom_range(0, GRID_X - 2));
      hot_y = IDX_W'($urandom_range(0, GRID_Y - 2));
      op = random_op();
      op.cmd = CMD_CLEAR;
      send_op(op, 1'b0, '0);
    end
    for (int i = 0; i < count; i++) send_op(hot ? hot_op() : random_op(), 1'b0, '0);
    settle();
  endtask

  // result side: random stalls, compare against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (cell_results_due.size() == 0) begin
          $error("result with nothing outstanding: cell_value %0h", cell_value);
          fail_count++;
        end else begin
          want_now = cell_results_due.pop_front();
          if (cell_value !== want_now.value) begin
            $error("cell_value: expected %0h, got %0h", want_now.value, cell_value);
            fail_count++;
          end
          if (dropped !== want_now.dropped) begin
            $error("dropped: expected %0b, got %0b", want_now.dropped, dropped);
            fail_count++;
          end
          if (saturated !== want_now.saturated) begin
            $error("saturated: expected %0b, got %0b", want_now.saturated, saturated);
            fail_count++;
          end
          if (dropped === 1'b1) n_drop_seen++;
          if (saturated === 1'b1) n_sat_seen++;
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= (stall_left == 1);
      end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 14);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $error("timeout after %0d cycles, %0d results outstanding",
             cycle_count, cell_results_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // the grid is wiped after reset before the first transfer
    while (!in_ready) @(posedge clk);
    foreach (DIRECTED_ROWS[i])
      send_op(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
    settle();
    for (int p = 0; p < 7; p++) run_phase(p);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d deposits, %0d reads, %0d clears; %0d results compared.",
             n_deposits, n_reads, n_clears, n_results);
    $display("Deposits with corners off the grid: %0d, with clipped cells: %0d.",
             n_drop_seen, n_sat_seen);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
